@@ hdl/positional_insert_remove_list_macros.svh @@
// assertion macros shared by the list rtl
`ifndef POSITIONAL_INSERT_REMOVE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_MACROS_SVH

// same-cycle implication, checked outside reset
`define PIR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PIR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pir_pkg.sv @@
// shared types, constants and helper functions for the positional list
`timescale 1ns / 1ps

package pir_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int ACT_W        = 2;
    localparam int STAT_W       = 2;
    localparam int OUT_CNT_W    = 8;
    localparam int CAPACITY_DEF = 128;
    localparam int FANIN        = 8;
    localparam int FANIN_LOG    = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_op_t                   op;
        logic [POS_W-1:0]           idx;
        logic signed [DATA_W-1:0]   value;
    } cell_ctl_t;

    // number of nodes at level k of the read-back or-tree
    function automatic int tree_size(input int n, input int k);
        int sh;
        sh = FANIN_LOG * k;
        return (n + (1 << sh) - 1) >> sh;
    endfunction

    // registered levels needed to fold n leaves down to one
    function automatic int tree_levels(input int n);
        int s;
        int l;
        s = n;
        l = 0;
        while (s > 1)
        begin
            s = (s + FANIN - 1) >> FANIN_LOG;
            l = l + 1;
        end
        return (l < 1) ? 1 : l;
    endfunction

endpackage

@@ hdl/pir_ifs.sv @@
// request and response channel interfaces of the positional list
`timescale 1ns / 1ps

interface pir_req_if;
    import pir_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACT_W-1:0]           action;
    logic [POS_W-1:0]           position;
    logic signed [DATA_W-1:0]   value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

interface pir_rsp_if;
    import pir_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   read_value;
    logic [STAT_W-1:0]          status;
    logic [OUT_CNT_W-1:0]       count;
    logic                       is_empty;
    logic                       is_full;

    modport source (output valid, output read_value, output status, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    input is_empty, input is_full, output ready);
endinterface

@@ hdl/positional_insert_remove_list.sv @@
// Positional insert/remove list: an ordered list of signed 32-bit words in a
// row of CAPACITY cells, addressed by one-based position.
// Channels: req (action, position, value) in, rsp (read_value, status, count,
// is_empty, is_full) out, both valid/ready; a transaction completes when valid
// and ready are high at a rising clk edge. One response per request.
// Overwrite, insert and remove take effect in the cycle the request is taken:
// every cell loads from itself, its left or right neighbor, or the new word at once.
// A read folds the selected cell through a registered 8-way or-tree of
// L = ceil(log8(CAPACITY)) levels (3 at the default capacity of 128).
// The request is registered, folds through the L levels, then loads the output.
// No new request is taken while the or-tree folds its predecessor;
// a new request is taken in the cycle its predecessor moves to the output.
// When rsp stalls, the finished response waits in the output register while
// the next request is still taken and worked on; the one after that waits.
// Reset (rst_n, asynchronous, active low) empties the list and drops any
// pending response; cell contents are not cleared and are never read unwritten.
`timescale 1ns / 1ps
`include "positional_insert_remove_list_macros.svh"

module positional_insert_remove_list #(
    parameter int CAPACITY = pir_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pir_req_if.sink     req,
    pir_rsp_if.source   rsp
);
    import pir_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int LVLS   = tree_levels(CAPACITY);
    localparam int STEP_W = $clog2(LVLS + 1);
    localparam logic signed [DATA_W-1:0] ERR_WORD = '1;

    // control state
    logic                   busy_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   out_valid_reg;

    // request held while the or-tree folds
    logic [POS_W-1:0]       rd_idx_reg;
    logic                   read_ok_reg;
    status_t                status_hold_reg;

    // output payload
    logic signed [DATA_W-1:0] read_value_reg;
    status_t                  status_reg;
    logic [OUT_CNT_W-1:0]     count_reg;
    logic                     is_empty_reg;
    logic                     is_full_reg;

    // decode
    logic                   accept;
    logic                   load;
    logic                   out_free;
    logic                   in_range;
    logic                   ins_range;
    logic                   list_full;
    logic                   read_ok;
    status_t                status_d;
    cell_ctl_t              ctl;
    logic [CMP_W-1:0]       pos_c;
    logic [CMP_W-1:0]       cnt_c;

    // cell row and read-back tree
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] rd_word   [CAPACITY];
    logic signed [DATA_W-1:0] node_reg  [LVLS][CAPACITY];

    // handshake
    assign out_free  = !out_valid_reg || rsp.ready;
    assign load      = busy_reg && (step_reg == STEP_W'(LVLS)) && out_free;
    assign req.ready = !busy_reg || load;
    assign accept    = req.valid && req.ready;

    // position checks against the current count
    assign pos_c     = CMP_W'(req.position);
    assign cnt_c     = CMP_W'(cnt_reg);
    assign in_range  = (req.position != '0) && (pos_c <= cnt_c);
    assign ins_range = (req.position != '0) && (pos_c <= cnt_c + CMP_W'(1));
    assign list_full = (cnt_reg == CNT_W'(CAPACITY));

    // request decode: status, count update and cell command
    always_comb
    begin
        status_d  = ST_OK;
        cnt_next  = cnt_reg;
        read_ok   = 1'b0;
        ctl.op    = CELL_HOLD;
        ctl.idx   = req.position - POS_W'(1);
        ctl.value = req.value;
        case (action_t'(req.action))
            ACT_READ:
            begin
                read_ok  = in_range;
                status_d = in_range ? ST_OK : ST_BADPOS;
            end
            ACT_WRITE:
            begin
                status_d = in_range ? ST_OK : ST_BADPOS;
                if (in_range)
                begin
                    ctl.op = CELL_WRITE;
                end
            end
            ACT_INSERT:
            begin
                if (list_full)
                begin
                    status_d = ST_FULL;
                end
                else if (ins_range)
                begin
                    ctl.op   = CELL_INSERT;
                    cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
                end
                else
                begin
                    status_d = ST_BADPOS;
                end
            end
            ACT_REMOVE:
            begin
                status_d = in_range ? ST_OK : ST_BADPOS;
                if (in_range)
                begin
                    ctl.op   = CELL_REMOVE;
                    cnt_next = CNT_W'(cnt_reg - CNT_W'(1));
                end
            end
            default:
            begin
                status_d = ST_BADPOS;
            end
        endcase
        if (!accept)
        begin
            ctl.op   = CELL_HOLD;
            cnt_next = cnt_reg;
        end
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pir_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .rd_idx     (rd_idx_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (rd_word[i])
        );
    end

    // registered or-tree folding the selected cell down to one word
    for (genvar k = 0; k < LVLS; k++)
    begin : g_lvl
        localparam int SRC = tree_size(CAPACITY, k);
        localparam int DST = tree_size(CAPACITY, k + 1);
        for (genvar j = 0; j < DST; j++)
        begin : g_node
            logic signed [DATA_W-1:0] node_next;
            if (k == 0)
            begin : g_leaf
                always_comb
                begin
                    node_next = '0;
                    for (int m = 0; m < FANIN; m++)
                    begin
                        if (j * FANIN + m < SRC)
                        begin
                            node_next = node_next | rd_word[j * FANIN + m];
                        end
                    end
                end
            end
            else
            begin : g_inner
                always_comb
                begin
                    node_next = '0;
                    for (int m = 0; m < FANIN; m++)
                    begin
                        if (j * FANIN + m < SRC)
                        begin
                            node_next = node_next | node_reg[k-1][j * FANIN + m];
                        end
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                node_reg[k][j] <= node_next;
            end
        end
    end

    // control: busy flag, fold step, list count, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && (step_reg != STEP_W'(LVLS)))
            begin
                step_reg <= STEP_W'(step_reg + STEP_W'(1));
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request hold and output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            read_value_reg <= read_ok_reg ? node_reg[LVLS-1][0] : ERR_WORD;
            status_reg     <= status_hold_reg;
            count_reg      <= OUT_CNT_W'(cnt_reg);
            is_empty_reg   <= (cnt_reg == '0);
            is_full_reg    <= (cnt_reg == CNT_W'(CAPACITY));
        end
        if (accept)
        begin
            rd_idx_reg      <= req.position - POS_W'(1);
            read_ok_reg     <= read_ok;
            status_hold_reg <= status_d;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.count      = count_reg;
    assign rsp.is_empty   = is_empty_reg;
    assign rsp.is_full    = is_full_reg;

    // checks
    `PIR_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PIR_ASSERT_NXT(a_accept_busy, accept, busy_reg && (step_reg == '0), "fold not restarted")
    `PIR_ASSERT_IMP(a_step_bound, busy_reg, step_reg <= STEP_W'(LVLS), "fold step overrun")
    `PIR_ASSERT_IMP(a_err_word, out_valid_reg && (status_reg != ST_OK), read_value_reg == ERR_WORD, "error response without error word")
    `PIR_ASSERT_IMP(a_full_flag, out_valid_reg && (status_reg == ST_FULL), is_full_reg && !is_empty_reg, "full refusal on a list not full")

endmodule

@@ hdl/pir_cell.sv @@
// one storage cell of the list row, shifts with its neighbors
`timescale 1ns / 1ps

module pir_cell #(
    parameter int CAPACITY = pir_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  logic                                    clk,
    input  pir_pkg::cell_ctl_t                      ctl,
    input  logic [pir_pkg::POS_W-1:0]               rd_idx,
    input  logic signed [pir_pkg::DATA_W-1:0]       left_data,
    input  logic signed [pir_pkg::DATA_W-1:0]       right_data,
    output logic signed [pir_pkg::DATA_W-1:0]       data,
    output logic signed [pir_pkg::DATA_W-1:0]       rd_data
);
    import pir_pkg::*;

    localparam bit IS_LAST = (INDEX == CAPACITY - 1);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit;
    logic                     above;
    logic                     rd_hit;

    // position compare against the broadcast index
    assign hit    = (INDEX == int'(ctl.idx));
    assign above  = (INDEX >  int'(ctl.idx));
    assign rd_hit = (INDEX == int'(rd_idx));

    // next entry: hold, take a new word, or shift from a neighbor
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_WRITE:
            begin
                if (hit)
                begin
                    data_next = ctl.value;
                end
            end
            CELL_INSERT:
            begin
                if (above)
                begin
                    data_next = left_data;
                end
                else if (hit)
                begin
                    data_next = ctl.value;
                end
            end
            CELL_REMOVE:
            begin
                if ((hit || above) && !IS_LAST)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // entry storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = rd_hit ? data_reg : '0;

endmodule
